// File: hw/rtl/bounded_position_deque_top_macros.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_POSITION_DEQUE_TOP_MACROS_SVH
`define BOUNDED_POSITION_DEQUE_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define BPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off during reset
`define BPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/bpd_pkg.sv
`default_nettype none

package bpd_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int COORD_W      = 8;
   localparam int INDEX_W      = 8;
   localparam int COUNT_OUT_W  = 9;

   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_REM_HEAD = 3'd2,
      OP_REM_TAIL = 3'd3,
      OP_READ     = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADIDX = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] symbol;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } entry_type;

   // Broadcast to every cell for one accepted word
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic write_tail;
      logic drop_tail;
      logic read_go;
   } cell_cmd_type;

   // Read word walking toward the head cell
   typedef struct packed {
      logic      valid;
      entry_type data;
   } carry_type;

endpackage

`default_nettype wire

// File: hw/rtl/bpd_cell.sv
`default_nettype none

module bpd_cell import bpd_pkg::*; #(
   parameter int CNT_W = 9,
   parameter int POS   = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_cmd_type       cmd,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic [INDEX_W-1:0] index,
   input  wire entry_type          new_entry,
   input  wire entry_type          prev_entry,
   input  wire entry_type          next_entry,
   input  wire carry_type          carry_in,
   output entry_type               entry,
   output carry_type               carry_out
);

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   entry_type entry_ff, entry_in;
   logic      carry_valid_ff, carry_valid_in;
   entry_type carry_data_ff, carry_data_in;
   logic      tail_hit;
   logic      drop_hit;
   logic      read_hit;

   assign tail_hit = (count == CNT_W'(POS));
   assign drop_hit = (count == CNT_W'(POS + 1));
   assign read_hit = (CMP_W'(index) == CMP_W'(POS));

   // Take the slot's next value: shift, append, clear or hold
   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.shift_up) begin
         entry_in = prev_entry;
      end else if (cmd.shift_down) begin
         entry_in = next_entry;
      end else if (cmd.write_tail && tail_hit) begin
         entry_in = new_entry;
      end else if (cmd.drop_tail && drop_hit) begin
         entry_in = '0;
      end
   end

   // Load the read word here, otherwise pass the neighbor's word toward the head
   always_comb begin
      if (cmd.read_go && read_hit) begin
         carry_valid_in = 1'b1;
         carry_data_in  = entry_ff;
      end else begin
         carry_valid_in = carry_in.valid;
         carry_data_in  = carry_in.data;
      end
   end

   always_ff @(posedge clock) begin
      carry_data_ff <= carry_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff       <= '0;
         carry_valid_ff <= 1'b0;
      end else begin
         entry_ff       <= entry_in;
         carry_valid_ff <= carry_valid_in;
      end
   end

   assign entry           = entry_ff;
   assign carry_out.valid = carry_valid_ff;
   assign carry_out.data  = carry_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_position_deque_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | opcode, new_x, new_y, new_symbol, index
// rsp     | out       | rsp_valid, rsp_stall | read_x, read_y, read_symbol, count, status
//
// Inserts, removes, spare opcodes, rejected words and reads past the count load
// their result into the output register at the accepting edge.
// A read at index k walks the entry along the carry chain one cell per cycle to
// the head cell; req_stall is high while it walks.
// req_stall is also high while a result waits under rsp_stall.
// Reset is synchronous and clears the count, control and every cell.
`default_nettype none

module bounded_position_deque_top import bpd_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_opcode,
   input  wire logic [COORD_W-1:0]     req_new_x,
   input  wire logic [COORD_W-1:0]     req_new_y,
   input  wire logic [COORD_W-1:0]     req_new_symbol,
   input  wire logic [INDEX_W-1:0]     req_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_W-1:0]          rsp_read_x,
   output logic [COORD_W-1:0]          rsp_read_y,
   output logic [COORD_W-1:0]          rsp_read_symbol,
   output logic [COUNT_OUT_W-1:0]      rsp_count,
   output logic [1:0]                  rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff;
   entry_type            rsp_entry_ff, rsp_entry_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_load;
   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   logic                 bad_index;
   logic [EXT_W-1:0]     count_ext;
   cell_cmd_type         cmd;
   entry_type            new_entry;
   entry_type            entry_w [CAPACITY];
   carry_type            carry_w [CAPACITY+1];

   assign new_entry.x      = req_new_x;
   assign new_entry.y      = req_new_y;
   assign new_entry.symbol = req_new_symbol;

   // Hold off new words while a read walks or the result cannot drain
   assign req_stall = (state_ff == S_READ) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign bad_index = (CMP_W'(req_index) >= CMP_W'(count_ff));

   // Next state, count update, cell commands and result load
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd           = '0;
      rsp_load      = 1'b0;
      rsp_entry_in  = '0;
      rsp_status_in = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               unique case (opcode_type'(req_opcode))
                  OP_INS_HEAD: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  OP_INS_TAIL: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd.write_tail = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REM_HEAD: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        cmd.shift_down = 1'b1;
                        count_in       = count_ff - CNT_W'(1);
                     end
                  end
                  OP_REM_TAIL: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        cmd.drop_tail = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (bad_index) begin
                        rsp_status_in = STAT_BADIDX;
                     end else begin
                        cmd.read_go = 1'b1;
                        rsp_load    = 1'b0;
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (carry_w[0].valid) begin
               rsp_load     = 1'b1;
               rsp_entry_in = carry_w[0].data;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count_ext = EXT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the result word
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_entry_ff  <= rsp_entry_in;
         rsp_count_ff  <= count_ext[COUNT_OUT_W-1:0];
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Row of slot cells, head at cell 0
   assign carry_w[CAPACITY] = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      entry_type prev_w;
      entry_type next_w;
      if (g == 0) begin : g_head
         assign prev_w = new_entry;
      end else begin : g_body
         assign prev_w = entry_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign next_w = '0;
      end else begin : g_inner
         assign next_w = entry_w[g+1];
      end
      bpd_cell #(
         .CNT_W (CNT_W),
         .POS   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .count      (count_ff),
         .index      (req_index),
         .new_entry  (new_entry),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .carry_in   (carry_w[g+1]),
         .entry      (entry_w[g]),
         .carry_out  (carry_w[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_x      = rsp_entry_ff.x;
   assign rsp_read_y      = rsp_entry_ff.y;
   assign rsp_read_symbol = rsp_entry_ff.symbol;
   assign rsp_count       = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bpd_checker.sv
`default_nettype none

`include "bounded_position_deque_top_macros.svh"

module bpd_checker import bpd_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic [2:0]             req_opcode,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [COORD_W-1:0]     rsp_read_x,
   input wire logic [COORD_W-1:0]     rsp_read_y,
   input wire logic [COORD_W-1:0]     rsp_read_symbol,
   input wire logic [COUNT_OUT_W-1:0] rsp_count,
   input wire logic [1:0]             rsp_status
);

   localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

   // A waiting result stays offered
   `BPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Any word other than a read answers in the next cycle
   `BPD_ASSERT_NEXT(a_quick_rsp, clock, reset,
      req_valid && !req_stall && (req_opcode != OP_READ), rsp_valid)

   // Rejected or failed words carry no entry
   `BPD_ASSERT_NOW(a_err_zero, clock, reset,
      rsp_valid && (rsp_status != STAT_OK),
      (rsp_read_x == '0) && (rsp_read_y == '0) && (rsp_read_symbol == '0))

   // A full rejection reports the full count
   `BPD_ASSERT_NOW(a_full_cnt, clock, reset,
      rsp_valid && (rsp_status == STAT_FULL), rsp_count == CAP_OUT)

   // An empty rejection reports a zero count
   `BPD_ASSERT_NOW(a_empty_cnt, clock, reset,
      rsp_valid && (rsp_status == STAT_EMPTY), rsp_count == '0)

endmodule

bind bounded_position_deque_top bpd_checker #(
   .CAPACITY (CAPACITY)
) u_bpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_opcode      (req_opcode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_x      (rsp_read_x),
   .rsp_read_y      (rsp_read_y),
   .rsp_read_symbol (rsp_read_symbol),
   .rsp_count       (rsp_count),
   .rsp_status      (rsp_status)
);

`default_nettype wire

// File: test/tb_bounded_position_deque_top.sv
`default_nettype none

module tb_bounded_position_deque_top import bpd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = CAPACITY_DEF;

   // Opcodes the block leaves unused
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] symbol;
      logic [INDEX_W-1:0] index;
   } list_word_type;

   typedef struct packed {
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      logic [COORD_W-1:0]     symbol;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
   } list_reply_type;

   typedef struct {
      list_word_type  word;
      bit             typed;
      list_reply_type reply;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [2:0]             req_opcode;
   logic [COORD_W-1:0]     req_new_x;
   logic [COORD_W-1:0]     req_new_y;
   logic [COORD_W-1:0]     req_new_symbol;
   logic [INDEX_W-1:0]     req_index;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_W-1:0]     rsp_read_x;
   logic [COORD_W-1:0]     rsp_read_y;
   logic [COORD_W-1:0]     rsp_read_symbol;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic [1:0]             rsp_status;

   // Mirror of the list contents
   entry_type      deque_store [DEPTH];
   int             held_count;
   list_reply_type awaited_replies [$];
   dir_row_type    dir_rows [$];
   list_reply_type want_reply;
   int             mismatch_count;
   int             stall_left;
   bit             no_gaps;

   bounded_position_deque_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_new_x       (req_new_x),
      .req_new_y       (req_new_y),
      .req_new_symbol  (req_new_symbol),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_x      (rsp_read_x),
      .rsp_read_y      (rsp_read_y),
      .rsp_read_symbol (rsp_read_symbol),
      .rsp_count       (rsp_count),
      .rsp_status      (rsp_status)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Apply one list operation to the mirror and return its reply
   function automatic list_reply_type apply_list_op(list_word_type w);
      list_reply_type r;
      entry_type      e;
      int             i;
      r = '0;
      r.status = STAT_OK;
      e.x = w.x;
      e.y = w.y;
      e.symbol = w.symbol;
      unique case (w.opcode)
         OP_INS_HEAD: begin
            if (held_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (i = held_count; i > 0; i--) deque_store[i] = deque_store[i-1];
               deque_store[0] = e;
               held_count++;
            end
         end
         OP_INS_TAIL: begin
            if (held_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               deque_store[held_count] = e;
               held_count++;
            end
         end
         OP_REM_HEAD: begin
            if (held_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               for (i = 0; i + 1 < held_count; i++) deque_store[i] = deque_store[i+1];
               deque_store[held_count-1] = '0;
               held_count--;
            end
         end
         OP_REM_TAIL: begin
            if (held_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               deque_store[held_count-1] = '0;
               held_count--;
            end
         end
         OP_READ: begin
            if (int'(w.index) < held_count && int'(w.index) < DEPTH) begin
               r.x = deque_store[w.index].x;
               r.y = deque_store[w.index].y;
               r.symbol = deque_store[w.index].symbol;
            end else begin
               r.status = STAT_BADIDX;
            end
         end
         default: ;
      endcase
      r.count = COUNT_OUT_W'(held_count);
      return r;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Build a random word with the given insert and remove shares in percent
   function automatic list_word_type random_list_word(int ins_pct, int rem_pct);
      list_word_type w;
      int            pick;
      w.x = 8'($urandom);
      w.y = 8'($urandom);
      w.symbol = 8'($urandom);
      w.index = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) begin
         w.opcode = $urandom_range(0, 1) ? OP_INS_TAIL : OP_INS_HEAD;
      end else if (pick < ins_pct + rem_pct) begin
         w.opcode = $urandom_range(0, 1) ? OP_REM_TAIL : OP_REM_HEAD;
      end else if (pick < ins_pct + rem_pct + 4) begin
         w.opcode = 3'($urandom_range(int'(OP_SPARE_HI), int'(OP_SPARE_LO)));
      end else begin
         w.opcode = OP_READ;
         // mostly land inside the held range
         if (held_count > 0 && $urandom_range(0, 4) != 0)
            w.index = 8'($urandom_range(0, held_count - 1));
      end
      return w;
   endfunction

   function automatic void add_row(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                   logic [7:0] s, logic [7:0] idx, bit typed,
                                   logic [7:0] ex_x, logic [7:0] ex_y, logic [7:0] ex_s,
                                   logic [8:0] ex_cnt, status_type ex_st);
      dir_row_type row;
      row.word = '{opcode: op, x: x, y: y, symbol: s, index: idx};
      row.typed = typed;
      row.reply = '{x: ex_x, y: ex_y, symbol: ex_s, count: ex_cnt, status: ex_st};
      dir_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string what, logic [8:0] want, logic [8:0] got);
      mismatch_count++;
      $display("tb: mismatch on %s, want %0h got %0h at %0t", what, want, got, $time);
   endtask

   // Present one word, hold it until taken, then record its reply
   task automatic drive_word(list_word_type w, bit typed, list_reply_type typed_reply);
      int             gap;
      list_reply_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= w.opcode;
      req_new_x <= w.x;
      req_new_y <= w.y;
      req_new_symbol <= w.symbol;
      req_index <= w.index;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = apply_list_op(w);
      awaited_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Stall the reply side in runs
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // Compare each taken reply with the oldest one awaited
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("unexpected reply", '0, rsp_count);
         end else begin
            want_reply = awaited_replies.pop_front();
            if (rsp_read_x !== want_reply.x) report_mismatch("read_x", want_reply.x, rsp_read_x);
            if (rsp_read_y !== want_reply.y) report_mismatch("read_y", want_reply.y, rsp_read_y);
            if (rsp_read_symbol !== want_reply.symbol)
               report_mismatch("read_symbol", want_reply.symbol, rsp_read_symbol);
            if (rsp_count !== want_reply.count)
               report_mismatch("count", want_reply.count, rsp_count);
            if (rsp_status !== want_reply.status)
               report_mismatch("status", want_reply.status, rsp_status);
         end
      end
   end

   initial begin
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_READ;
      req_new_x = '0;
      req_new_y = '0;
      req_new_symbol = '0;
      req_index = '0;
      held_count = 0;
      mismatch_count = 0;
      stall_left = 0;
      no_gaps = 1'b0;
      for (k = 0; k < DEPTH; k++) deque_store[k] = '0;

      // Directed words: empty list, extremes, spare opcodes, drain back to empty
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 0, STAT_BADIDX);
      add_row(OP_REM_HEAD, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 0, 0, 0, STAT_EMPTY);
      add_row(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 0, STAT_EMPTY);
      add_row(OP_INS_HEAD, 8'hff, 8'hff, 8'hff, 8'h00, 1, 0, 0, 0, 1, STAT_OK);
      add_row(OP_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'hff, 1, 0, 0, 0, 2, STAT_OK);
      add_row(OP_INS_HEAD, 8'h5a, 8'ha5, 8'h3c, 8'h00, 1, 0, 0, 0, 3, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h5a, 8'ha5, 8'h3c, 3, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h01, 1, 8'hff, 8'hff, 8'hff, 3, STAT_OK);
      add_row(OP_READ,     8'hff, 8'hff, 8'hff, 8'h02, 1, 0, 0, 0, 3, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h03, 1, 0, 0, 0, 3, STAT_BADIDX);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'hff, 1, 0, 0, 0, 3, STAT_BADIDX);
      add_row(OP_SPARE_LO, 8'hff, 8'hff, 8'hff, 8'h00, 1, 0, 0, 0, 3, STAT_OK);
      add_row(OP_SPARE_MID, 8'h11, 8'h22, 8'h33, 8'h01, 1, 0, 0, 0, 3, STAT_OK);
      add_row(OP_SPARE_HI, 8'hff, 8'hff, 8'hff, 8'hff, 1, 0, 0, 0, 3, STAT_OK);
      add_row(OP_INS_TAIL, 8'h01, 8'h80, 8'h7f, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h01, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);
      add_row(OP_READ,     8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, STAT_OK);

      // Hold reset, then release
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < dir_rows.size(); k++)
         drive_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].reply);

      // Back-to-back mixed traffic with no gaps on either side
      no_gaps = 1'b1;
      repeat (60) drive_word(random_list_word(45, 30), 1'b0, '0);
      no_gaps = 1'b0;

      // Fill to capacity, poke the full list, drain, poke the empty list
      while (held_count < DEPTH) drive_word(random_list_word(85, 5), 1'b0, '0);
      repeat (4) drive_word(random_list_word(100, 0), 1'b0, '0);
      while (held_count > 0) drive_word(random_list_word(5, 85), 1'b0, '0);
      repeat (4) drive_word(random_list_word(0, 100), 1'b0, '0);

      // Mixed traffic with gaps
      repeat (120) drive_word(random_list_word(40, 35), 1'b0, '0);
      req_valid <= 1'b0;

      // Drain outstanding replies, then watch for strays
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
